>>> sv/eptm_pkg.sv
// Shared types and constants for the page table mapper.
// No dependencies.
package eptm_pkg;
	localparam int unsigned POOL_PAGES_DEF = 256;
	localparam int unsigned GUEST_FRAME_BITS_DEF = 36;
	localparam int unsigned FRAME_LSB = 12;
	localparam int unsigned FRAME_W = 40;
	localparam int unsigned ENTRY_W = 52;
	localparam int unsigned GFN_W = 36;
	localparam int unsigned IDX_W = 9;
	localparam logic [2:0] DIR_RWX = 3'b111;

	typedef struct packed {
		logic [GFN_W-1:0] guest_frame;
		logic [FRAME_W-1:0] host_frame;
		logic [2:0] access_bits;
		logic [2:0] memory_type;
		logic keep_host_frame;
	} req_t;

	typedef struct packed {
		logic status;
		logic [ENTRY_W-1:0] leaf_entry;
		logic [1:0] tables_added;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_RD, ST_WAIT, ST_CHK, ST_RD2, ST_WAIT2, ST_UPD, ST_LEAF, ST_OUT
	} walk_st_t;
endpackage

>>> sv/eptm_if.sv
// Valid/ready channel interface carrying one payload type.
// No dependencies.
interface eptm_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/eptm_front.sv
// Front end: accepts requests and holds them in a two-entry queue.
// Depends on eptm_pkg.
module eptm_front import eptm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input req_t in_data,
	output logic q_valid,
	input logic q_ready,
	output req_t q_data
);
	req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rp_q];
	assign push = in_valid && in_ready;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> sv/eptm_walk.sv
// Back end: walks and updates the four-level table held in one memory.
// Depends on eptm_pkg.
module eptm_walk import eptm_pkg::*; #(
	parameter int unsigned POOL_PAGES = POOL_PAGES_DEF,
	parameter int unsigned GUEST_FRAME_BITS = GUEST_FRAME_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic [FRAME_W-1:0] pool_base_frame,
	input logic q_valid,
	output logic q_ready,
	input req_t q_data,
	output logic out_valid,
	input logic out_ready,
	output rsp_t out_data
);
	localparam int unsigned PG_W = $clog2(POOL_PAGES + 1);
	localparam int unsigned DEPTH = (POOL_PAGES + 1) * 512;
	localparam int unsigned A_W = $clog2(DEPTH);

	logic [ENTRY_W-1:0] mem [DEPTH];
	logic [ENTRY_W-1:0] rd_q;
	logic [A_W-1:0] addr;
	logic we;
	logic [ENTRY_W-1:0] wd;

	walk_st_t st_q, st_d;
	req_t req_q;
	logic [1:0] lvl_q;
	logic [PG_W-1:0] used_q, page_q;
	logic [1:0] miss_q;
	logic [A_W-1:0] clr_q;
	rsp_t rsp_q;
	logic [ENTRY_W-1:0] leaf;

	logic [GFN_W-1:0] g;
	logic [IDX_W-1:0] idx;
	logic [FRAME_W-1:0] rel;
	logic stale;
	logic [PG_W:0] need;

	assign g = q_data.guest_frame & GFN_W'((37'd1 << GUEST_FRAME_BITS) - 37'd1);

	always_comb begin
		unique case (lvl_q)
			2'd0: idx = req_q.guest_frame[35:27];
			2'd1: idx = req_q.guest_frame[26:18];
			2'd2: idx = req_q.guest_frame[17:9];
			default: idx = req_q.guest_frame[8:0];
		endcase
	end

	assign addr = (st_q == ST_CLEAR) ? clr_q
		: A_W'(({{(A_W-PG_W){1'b0}}, page_q}) * A_W'(512)) + A_W'(idx);
	assign rel = rd_q[FRAME_LSB +: FRAME_W] - pool_base_frame;
	assign stale = (rel >= FRAME_W'(used_q));
	assign need = {1'b0, used_q} + (PG_W+1)'(2'd3 - lvl_q);

	always_comb begin
		leaf = {rd_q[ENTRY_W-1:7], 7'd0};
		if (!req_q.keep_host_frame) leaf[FRAME_LSB +: FRAME_W] = req_q.host_frame;
		leaf[6:0] = {1'b1, req_q.memory_type, req_q.access_bits};
	end

	always_comb begin
		we = 1'b0;
		wd = '0;
		unique case (st_q)
			ST_CLEAR: we = 1'b1;
			ST_UPD: if (!rd_q[0]) begin
				we = 1'b1;
				wd = {FRAME_W'(pool_base_frame + FRAME_W'(used_q)), 9'd0, DIR_RWX};
			end
			ST_LEAF: begin
				we = 1'b1;
				wd = leaf;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wd;
		rd_q <= mem[addr];
	end

	// Pass one reads (ST_RD..ST_CHK), pass two builds (ST_RD2..ST_LEAF).
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLEAR: if (clr_q == A_W'(DEPTH - 1)) st_d = ST_IDLE;
			ST_IDLE: if (q_valid) st_d = ST_RD;
			ST_RD: st_d = ST_WAIT;
			ST_WAIT: st_d = ST_CHK;
			ST_CHK: begin
				if (!rd_q[0]) st_d = (need > (PG_W+1)'(POOL_PAGES)) ? ST_OUT : ST_RD2;
				else if (stale) st_d = ST_OUT;
				else if (lvl_q == 2'd2) st_d = ST_RD2;
				else st_d = ST_RD;
			end
			ST_RD2: st_d = ST_WAIT2;
			ST_WAIT2: st_d = (lvl_q == 2'd3) ? ST_LEAF : ST_UPD;
			ST_UPD: st_d = ST_RD2;
			ST_LEAF: st_d = ST_OUT;
			ST_OUT: if (out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	assign q_ready = (st_q == ST_IDLE);
	assign out_valid = (st_q == ST_OUT);
	assign out_data = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			used_q <= '0;
			lvl_q <= '0;
			page_q <= '0;
			miss_q <= '0;
		end else begin
			st_q <= st_d;
			unique case (st_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: if (q_valid) begin
					lvl_q <= '0;
					page_q <= '0;
					miss_q <= '0;
				end
				ST_CHK: begin
					if (!rd_q[0]) begin
						miss_q <= 2'd3 - lvl_q;
						lvl_q <= '0;
						page_q <= '0;
					end else if (!stale) begin
						if (lvl_q == 2'd2) begin
							lvl_q <= '0;
							page_q <= '0;
						end else begin
							lvl_q <= lvl_q + 1'b1;
							page_q <= PG_W'(rel) + 1'b1;
						end
					end
				end
				ST_UPD: begin
					lvl_q <= lvl_q + 1'b1;
					if (!rd_q[0]) begin
						used_q <= used_q + 1'b1;
						page_q <= used_q + 1'b1;
					end else page_q <= PG_W'(rel) + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid) begin
			req_q <= '{guest_frame: g, host_frame: q_data.host_frame,
				access_bits: q_data.access_bits, memory_type: q_data.memory_type,
				keep_host_frame: q_data.keep_host_frame};
		end
		if (st_q == ST_CHK && st_d == ST_OUT) rsp_q <= '{status: 1'b1, leaf_entry: '0,
			tables_added: 2'd0};
		if (st_q == ST_LEAF) rsp_q <= '{status: 1'b0, leaf_entry: leaf,
			tables_added: miss_q};
	end
endmodule

>>> sv/ept_page_table_mapper.sv
// Four-level page table mapper: front queue plus table walk engine.
// The walk handles one request at a time and takes the next only after the
// response beat; a refusal at the root ends the walk early, and a walk through
// present levels waits on each dependent table read in turn.
// Reset: asynchronous; then a clearing pass sweeps the table memory, during
// which the walk takes no request.
module ept_page_table_mapper import eptm_pkg::*; #(
	parameter int unsigned POOL_PAGES = POOL_PAGES_DEF,
	parameter int unsigned GUEST_FRAME_BITS = GUEST_FRAME_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	eptm_if.sink cfg,
	eptm_if.sink req,
	eptm_if.source rsp
);
	logic [FRAME_W-1:0] pool_base_q;
	logic qv, qr;
	req_t qd;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pool_base_q <= '0;
		else if (cfg.valid) pool_base_q <= cfg.data;
	end

	eptm_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
		.q_valid(qv), .q_ready(qr), .q_data(qd)
	);

	eptm_walk #(.POOL_PAGES(POOL_PAGES), .GUEST_FRAME_BITS(GUEST_FRAME_BITS)) u_walk (
		.clk(clk), .arst_n(arst_n), .pool_base_frame(pool_base_q),
		.q_valid(qv), .q_ready(qr), .q_data(qd),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
	);
endmodule

>>> dv/ept_map_checker.sv
`timescale 1ns / 100ps
// Watches the config, request and response channels of the page table mapper,
// predicts every response and compares it field by field.
// Depends on eptm_pkg and eptm_if.
module ept_map_checker import eptm_pkg::*; (
	input logic clk,
	input logic arst_n,
	eptm_if cfg_mon,
	eptm_if req_mon,
	eptm_if rsp_mon,
	output int fail_count,
	output int pending
);
	localparam int unsigned POOL = POOL_PAGES_DEF;
	localparam int unsigned TBL_N = 512;

	logic [ENTRY_W-1:0] tbl_mem [int];
	logic [FRAME_W-1:0] pool_base;
	int unsigned pages_taken;
	rsp_t rsp_expected_q[$];

	function automatic logic [ENTRY_W-1:0] tbl_rd(int addr);
		return tbl_mem.exists(addr) ? tbl_mem[addr] : '0;
	endfunction

	// Pool page that a present directory entry points at; 0 when not a taken page.
	function automatic bit dir_page(logic [ENTRY_W-1:0] ent, output int unsigned pg);
		logic [FRAME_W-1:0] d;
		d = ent[ENTRY_W-1:FRAME_LSB] - pool_base;
		pg = 32'(d);
		return d < pages_taken;
	endfunction

	function automatic rsp_t map_predict(req_t r);
		rsp_t res;
		logic [GFN_W-1:0] g;
		int unsigned ix [4];
		int unsigned off, pg, missing, slot;
		logic [ENTRY_W-1:0] ent, leaf;
		logic [FRAME_W-1:0] fr;
		res = '0;
		g = r.guest_frame & ((GFN_W'(1) << GUEST_FRAME_BITS_DEF) - 1);
		if (GUEST_FRAME_BITS_DEF >= GFN_W)
			g = r.guest_frame;
		ix[0] = 32'(g[35:27]); ix[1] = 32'(g[26:18]); ix[2] = 32'(g[17:9]);
		ix[3] = 32'(g[8:0]);
		off = 0;
		missing = 0;
		// dry walk: count missing directories, refuse stale pointers
		for (int l = 0; l < 3; l++) begin
			ent = tbl_rd(off + ix[l]);
			if (!ent[0]) begin
				missing = 3 - l;
				break;
			end
			if (!dir_page(ent, pg)) begin
				res.status = 1'b1;
				return res;
			end
			off = (pg + 1) * TBL_N;
		end
		if (pages_taken + missing > POOL) begin
			res.status = 1'b1;
			return res;
		end
		off = 0;
		for (int l = 0; l < 3; l++) begin
			slot = off + ix[l];
			ent = tbl_rd(slot);
			if (!ent[0]) begin
				pg = pages_taken;
				pages_taken++;
				fr = pool_base + FRAME_W'(pg);
				tbl_mem[slot] = {fr, 9'd0, DIR_RWX};
			end else begin
				void'(dir_page(ent, pg));
			end
			off = (pg + 1) * TBL_N;
		end
		slot = off + ix[3];
		leaf = tbl_rd(slot);
		leaf[6:0] = '0;
		if (!r.keep_host_frame)
			leaf[ENTRY_W-1:FRAME_LSB] = r.host_frame;
		leaf[2:0] = r.access_bits;
		leaf[5:3] = r.memory_type;
		leaf[6] = 1'b1;
		tbl_mem[slot] = leaf;
		res.leaf_entry = leaf;
		res.tables_added = missing[1:0];
		return res;
	endfunction

	assign pending = rsp_expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t want, got;
		if (!arst_n) begin
			tbl_mem.delete();
			pool_base = '0;
			pages_taken = 0;
			rsp_expected_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready)
				pool_base = cfg_mon.data;
			if (req_mon.valid && req_mon.ready)
				rsp_expected_q.push_back(map_predict(req_mon.data));
			if (rsp_mon.valid && rsp_mon.ready) begin
				got = rsp_mon.data;
				if (rsp_expected_q.size() == 0) begin
					fail_count++;
					$display("%0t: response beat with nothing expected: %h", $time, got);
				end else begin
					want = rsp_expected_q.pop_front();
					if (got.status !== want.status) begin
						fail_count++;
						$display("%0t: status expected %0d actual %0d", $time,
							want.status, got.status);
					end
					if (got.leaf_entry !== want.leaf_entry) begin
						fail_count++;
						$display("%0t: leaf_entry expected %h actual %h", $time,
							want.leaf_entry, got.leaf_entry);
					end
					if (got.tables_added !== want.tables_added) begin
						fail_count++;
						$display("%0t: tables_added expected %0d actual %0d", $time,
							want.tables_added, got.tables_added);
					end
				end
			end
		end
	end
endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// Top of the page table mapper testbench: clock, reset, stimulus and verdict.
// Depends on eptm_pkg, eptm_if, ept_map_checker and the mapper RTL.
module tb;
	import eptm_pkg::*;

	localparam logic [FRAME_W-1:0] BASE_WRAP = 40'hFF_FFFF_FFFE;
	localparam logic [FRAME_W-1:0] BASE_MAX = 40'hFF_FFFF_FFFF;

	logic clk;
	logic arst_n;
	int fail_count, pending;
	bit no_gaps;
	logic [GFN_W-1:0] guest_hist[$];

	eptm_if #(.T(logic [FRAME_W-1:0])) cfg_ch ();
	eptm_if #(.T(req_t)) req_ch ();
	eptm_if #(.T(rsp_t)) rsp_ch ();

	ept_page_table_mapper dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_ch), .req(req_ch), .rsp(rsp_ch)
	);

	ept_map_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_mon(cfg_ch), .req_mon(req_ch),
		.rsp_mon(rsp_ch), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#3000000;
		$display("ept_page_table_mapper verification failed");
		$finish;
	end

	function automatic int gap_len();
		int p;
		if (no_gaps)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 90) return $urandom_range(1, 3);
		if (p < 98) return $urandom_range(4, 20);
		return $urandom_range(30, 80);
	endfunction

	// Hold valid across back-to-back beats; drop it only for a real gap.
	task automatic send_req(input req_t r);
		int n;
		n = gap_len();
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		req_ch.data <= r;
		req_ch.valid <= 1'b1;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	task automatic write_base(input logic [FRAME_W-1:0] b);
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		cfg_ch.data <= b;
		cfg_ch.valid <= 1'b1;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic map_one(input logic [GFN_W-1:0] g, input logic [FRAME_W-1:0] h,
		input logic [2:0] acc, input logic [2:0] mt, input logic keep);
		req_t r;
		r.guest_frame = g;
		r.host_frame = h;
		r.access_bits = acc;
		r.memory_type = mt;
		r.keep_host_frame = keep;
		send_req(r);
		guest_hist.push_back(g);
		if (guest_hist.size() > 64)
			void'(guest_hist.pop_front());
	endtask

	// Clustered guests share upper directories so the pool lasts; full random drains it.
	task automatic map_random(input int count, input int full_pct, input int reuse_pct);
		logic [GFN_W-1:0] g;
		int p;
		for (int i = 0; i < count; i++) begin
			if (i % 200 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			p = $urandom_range(0, 99);
			if (p < full_pct) begin
				g = GFN_W'({$urandom, $urandom});
			end else if (p < full_pct + reuse_pct && guest_hist.size() > 0) begin
				g = guest_hist[$urandom_range(0, guest_hist.size() - 1)];
				if ($urandom_range(0, 1))
					g[8:0] = 9'($urandom);
			end else begin
				g[35:27] = ($urandom_range(0, 4) == 0) ? 9'h1FF : 9'($urandom_range(0, 2));
				g[26:18] = ($urandom_range(0, 4) == 0) ? 9'h1FF : 9'($urandom_range(0, 3));
				g[17:9] = 9'($urandom_range(0, 15));
				g[8:0] = 9'($urandom);
			end
			map_one(g, FRAME_W'({$urandom, $urandom}), 3'($urandom), 3'($urandom),
				$urandom_range(0, 3) == 0);
		end
	endtask

	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			int n;
			n = gap_len();
			if (n > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		no_gaps = 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// base near the top so pool frames wrap past zero
		write_base(BASE_WRAP);
		map_one('0, '0, 3'd0, 3'd0, 1'b0);
		map_one('0, '1, 3'd7, 3'd7, 1'b0);
		map_one('0, 40'h12_3456_789A, 3'd1, 3'd6, 1'b1);
		map_one('1, '1, 3'd2, 3'd1, 1'b0);
		map_one('1, '0, 3'd4, 3'd2, 1'b0);
		map_one(36'h0_0000_0001, 40'hAA_AAAA_AAAA, 3'd3, 3'd3, 1'b0);
		map_one(36'h0_0000_0200, 40'h55_5555_5555, 3'd5, 3'd4, 1'b0);
		map_one(36'h0_0004_0000, 40'h0F_0F0F_0F0F, 3'd6, 3'd5, 1'b0);
		map_one(36'h0_0800_0000, 40'hF0_F0F0_F0F0, 3'd7, 3'd6, 1'b0);
		// keep on a fresh leaf keeps a zero frame
		map_one(36'h5_5555_5555, '1, 3'd7, 3'd0, 1'b1);
		map_one(36'hA_AAAA_AAAA, 40'h80_0000_0001, 3'd0, 3'd7, 1'b0);
		map_one(36'hA_AAAA_AAAA, 40'h00_0000_0002, 3'd1, 3'd1, 1'b1);
		map_one(36'hA_AAAA_AAAB, 40'h00_0000_0003, 3'd2, 3'd2, 1'b0);
		map_one(36'hF_FFFF_FE00, 40'hFF_0000_00FF, 3'd4, 3'd6, 1'b0);
		map_one(36'h8_0000_0000, 40'h01_2345_6789, 3'd7, 3'd7, 1'b0);
		map_one(36'h0_0000_01FF, 40'hFE_DCBA_9876, 3'd3, 3'd5, 1'b0);
		map_random(600, 10, 20);

		// different base makes existing directories stale
		write_base('0);
		map_random(250, 10, 40);

		// restore and drain the pool until it runs out
		write_base(BASE_WRAP);
		map_random(500, 40, 20);

		write_base(BASE_MAX);
		map_random(150, 10, 40);

		write_base(BASE_WRAP);
		map_random(150, 5, 70);

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("ept_page_table_mapper verification clean");
		else
			$display("ept_page_table_mapper verification failed");
		$finish;
	end
endmodule
